FILE: rtl/tbba_pkg.sv
// ---------------------------------------------------------------------------
// tbba_pkg: shared types and constants for the bearing angles unit
// Holds field widths, CORDIC constants, the arctangent table and the
// word that travels from the front end to the back end.
// ---------------------------------------------------------------------------
`default_nettype none
package tbba_pkg;

   localparam int COORD_BITS  = 12;
   localparam int HW_BITS     = COORD_BITS - 1;
   localparam int VEC_W       = COORD_BITS + 2;
   localparam int PROD_W      = 2 * VEC_W - 1;
   localparam int SUM_W       = PROD_W + 1;
   localparam int MAG_W       = SUM_W - 1;
   localparam int SHIFT_W     = 6;
   localparam int NORM_TOP    = 40;
   localparam int CORDIC_W    = 45;
   localparam int Z_W         = 33;
   localparam int CORDIC_STEPS = 30;
   // Back end stages ahead of the output register: magnitudes, shift,
   // CORDIC load, the iterations, fold and scale.
   localparam int BACK_STAGES = CORDIC_STEPS + 5;
   localparam int ANGLE_W     = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int LANES       = 3;

   localparam logic [HW_BITS-1:0]    HALF_WIDTH_RESET   = HW_BITS'(1050);
   localparam logic [COORD_BITS-1:0] FIELD_LENGTH_RESET = COORD_BITS'(3000);
   localparam logic [15:0]           FULL_TURN_CDEG     = 16'd36000;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HALF_WIDTH   = 2'd0,
      CSR_FIELD_LENGTH = 2'd1
   } csr_index_type;

   typedef logic signed [PROD_W-1:0] prod_type;

   // Word handed from the front end to the back end: four products per
   // beacon pair (u.x*v.y, u.y*v.x, u.x*v.x, u.y*v.y) and the flags.
   typedef struct packed {
      logic [LANES-1:0][3:0][PROD_W-1:0] prod;
      logic refl_left;
      logic refl_right;
      logic degen;
   } word_type;

   // Arctangent table, unit 2^-32 of a turn.
   function automatic logic [Z_W-1:0] atan_entry(input int idx);
      logic [31:0] v;
      v = 32'd0;
      unique case (idx)
         0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
         3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
         6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
         9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
         12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
         15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
         18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
         21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
         24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
         27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
         default: v = 32'd0;
      endcase
      return {1'b0, v};
   endfunction

endpackage
`default_nettype wire

FILE: rtl/tbba_ifs.sv
// ---------------------------------------------------------------------------
// tbba channel interfaces
// Request, response and register-write channels with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none
interface tbba_req_if import tbba_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   modport source (output valid, pos_x, pos_y, input ready);
   modport sink   (input valid, pos_x, pos_y, output ready);
endinterface

interface tbba_rsp_if import tbba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] angle_top_pair;
   logic [ANGLE_W-1:0] angle_right_bottom;
   logic [ANGLE_W-1:0] angle_left_bottom;
   logic               degenerate;
   modport source (output valid, angle_top_pair, angle_right_bottom,
                   angle_left_bottom, degenerate, input ready);
   modport sink   (input valid, angle_top_pair, angle_right_bottom,
                   angle_left_bottom, degenerate, output ready);
endinterface

interface tbba_csr_if import tbba_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [COORD_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tbba_front.sv
// ---------------------------------------------------------------------------
// tbba_front: position intake
// Clamps the position, flags beacon hits, forms beacon vectors and their
// products, and decides the two reflex corrections.
// ---------------------------------------------------------------------------
`default_nettype none
module tbba_front import tbba_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [COORD_BITS-1:0] pos_x,
   input  wire logic [COORD_BITS-1:0] pos_y,
   input  wire logic [HW_BITS-1:0]    half_width,
   input  wire logic [COORD_BITS-1:0] field_length,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output word_type                   out_word
);
   logic                         a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;
   logic                         adv_a, adv_b;
   logic [COORD_BITS-1:0]        x_c, y_c, w2;
   logic                         degen_c;
   logic signed [VEC_W-1:0]      ux_c [LANES], uy_c [LANES], vx_c [LANES], vy_c [LANES];
   logic signed [VEC_W-1:0]      ux_ff [LANES], uy_ff [LANES], vx_ff [LANES], vy_ff [LANES];
   logic [COORD_BITS-1:0]        x_ff, y_ff, l_ff, w2_ff;
   logic [HW_BITS-1:0]           h_ff;
   logic                         degen_ff;
   word_type                     word_ff, word_in;
   logic signed [VEC_W-1:0]      ax, ay, bx, by, cx, cy;

   // Pipeline advance: stage B drains into the queue.
   assign adv_b    = !b_valid_ff || out_ready;
   assign adv_a    = !a_valid_ff || adv_b;
   assign in_ready = adv_a;
   assign a_valid_in = adv_a ? in_valid : a_valid_ff;
   assign b_valid_in = adv_b ? a_valid_ff : b_valid_ff;

   // Clamp, beacon-hit test and beacon vectors.
   always_comb begin
      w2 = {half_width, 1'b0};
      x_c = (pos_x > w2) ? w2 : pos_x;
      y_c = (pos_y > field_length) ? field_length : pos_y;
      degen_c = (x_c == COORD_BITS'(half_width) && y_c == '0) ||
                (x_c == '0 && y_c == field_length) ||
                (x_c == w2 && y_c == field_length);
      ax = -$signed({2'b00, x_c});
      ay = $signed({2'b00, field_length}) - $signed({2'b00, y_c});
      bx = $signed({2'b00, w2}) - $signed({2'b00, x_c});
      by = ay;
      cx = $signed({3'b000, half_width}) - $signed({2'b00, x_c});
      cy = -$signed({2'b00, y_c});
      // Lane 0: left-top and right-top; lane 1: right-top and bottom;
      // lane 2: left-top and bottom.
      ux_c[0] = ax; uy_c[0] = ay; vx_c[0] = bx; vy_c[0] = by;
      ux_c[1] = bx; uy_c[1] = by; vx_c[1] = cx; vy_c[1] = cy;
      ux_c[2] = ax; uy_c[2] = ay; vx_c[2] = cx; vy_c[2] = cy;
   end

   // Products and reflex tests.
   always_comb begin
      logic [2*COORD_BITS-1:0] lhs_l, lhs_r, rhs;
      word_in = word_ff;
      for (int k = 0; k < LANES; k++) begin
         word_in.prod[k][0] = PROD_W'(ux_ff[k]) * PROD_W'(vy_ff[k]);
         word_in.prod[k][1] = PROD_W'(uy_ff[k]) * PROD_W'(vx_ff[k]);
         word_in.prod[k][2] = PROD_W'(ux_ff[k]) * PROD_W'(vx_ff[k]);
         word_in.prod[k][3] = PROD_W'(uy_ff[k]) * PROD_W'(vy_ff[k]);
      end
      lhs_l = (2*COORD_BITS)'(x_ff) * (2*COORD_BITS)'(l_ff);
      lhs_r = (2*COORD_BITS)'(w2_ff - x_ff) * (2*COORD_BITS)'(l_ff);
      rhs   = (2*COORD_BITS)'(h_ff) * (2*COORD_BITS)'(l_ff - y_ff);
      word_in.refl_left  = lhs_l < rhs;
      word_in.refl_right = lhs_r < rhs;
      word_in.degen      = degen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         x_ff <= x_c; y_ff <= y_c; l_ff <= field_length; h_ff <= half_width;
         w2_ff <= w2; degen_ff <= degen_c;
         for (int k = 0; k < LANES; k++) begin
            ux_ff[k] <= ux_c[k]; uy_ff[k] <= uy_c[k];
            vx_ff[k] <= vx_c[k]; vy_ff[k] <= vy_c[k];
         end
      end
      if (adv_b) word_ff <= word_in;
   end

   assign out_valid = b_valid_ff;
   assign out_word  = word_ff;
endmodule
`default_nettype wire

FILE: rtl/tbba_queue.sv
// ---------------------------------------------------------------------------
// tbba_queue: short word queue
// Decouples the front end from the back end so either may stall alone.
// ---------------------------------------------------------------------------
`default_nettype none
module tbba_queue import tbba_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire word_type in_word,
   output logic          out_valid,
   input  wire logic     out_ready,
   output word_type      out_word
);
   word_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]       cnt_ff, cnt_in;
   logic                  push, pop;

   assign in_ready  = cnt_ff != (QPTR_W+1)'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_word  = mem_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_word;
   end
endmodule
`default_nettype wire

FILE: rtl/tbba_back.sv
// ---------------------------------------------------------------------------
// tbba_back: angle pipeline
// Per beacon pair: cross and dot, normalization, a 30-stage vectoring
// CORDIC, folding and scaling to centidegrees, then reflex correction.
// ---------------------------------------------------------------------------
`default_nettype none
module tbba_back import tbba_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire word_type in_word,
   tbba_rsp_if.source    rsp
);
   logic                    en;
   logic [BACK_STAGES-1:0]  v_ff, v_in;
   logic [BACK_STAGES-1:0]  rl_ff, rr_ff, dg_ff;
   logic                    rsp_valid_ff;

   // Stage 0: magnitudes and dot sign.
   logic [MAG_W-1:0]      ac_ff [LANES], ad_ff [LANES];
   logic                  neg0_ff [LANES];
   // Stage 1: normalizing shift.
   logic [MAG_W-1:0]      ac1_ff [LANES], ad1_ff [LANES];
   logic [SHIFT_W-1:0]    sh1_ff [LANES];
   logic                  neg1_ff [LANES];
   // CORDIC stages.
   logic signed [CORDIC_W-1:0] cx_ff [LANES][CORDIC_STEPS+1];
   logic signed [CORDIC_W-1:0] cy_ff [LANES][CORDIC_STEPS+1];
   logic signed [Z_W-1:0]      cz_ff [LANES][CORDIC_STEPS+1];
   logic                       cn_ff [LANES][CORDIC_STEPS+1];
   // Fold and scale.
   logic [31:0]           zf_ff [LANES];
   logic [47:0]           pr_ff [LANES];
   logic [ANGLE_W-1:0]    cd_c [LANES];
   logic [ANGLE_W-1:0]    a0_ff, a1_ff, a2_ff;
   logic                  deg_ff;

   assign en       = !rsp_valid_ff || rsp.ready;
   assign in_ready = en;

   // Valid and flag shift line along the stages.
   assign v_in = {v_ff[BACK_STAGES-2:0], in_valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff <= v_in;
         rsp_valid_ff <= v_ff[BACK_STAGES-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rl_ff <= {rl_ff[BACK_STAGES-2:0], in_word.refl_left};
         rr_ff <= {rr_ff[BACK_STAGES-2:0], in_word.refl_right};
         dg_ff <= {dg_ff[BACK_STAGES-2:0], in_word.degen};
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic signed [SUM_W-1:0] crs_c, dot_c;
      logic [SHIFT_W-1:0]      sh_c;
      logic [MAG_W-1:0]        m_c;

      // Cross and dot products and their magnitudes.
      always_comb begin
         crs_c = SUM_W'($signed(in_word.prod[k][0])) - SUM_W'($signed(in_word.prod[k][1]));
         dot_c = SUM_W'($signed(in_word.prod[k][2])) + SUM_W'($signed(in_word.prod[k][3]));
      end
      always_ff @(posedge clock) begin
         if (en) begin
            ac_ff[k]  <= MAG_W'(crs_c[SUM_W-1] ? -crs_c : crs_c);
            ad_ff[k]  <= MAG_W'(dot_c[SUM_W-1] ? -dot_c : dot_c);
            neg0_ff[k] <= dot_c[SUM_W-1];
         end
      end

      // Leading-one search picks the shift that puts the top bit at NORM_TOP.
      always_comb begin
         m_c  = (ac_ff[k] > ad_ff[k]) ? ac_ff[k] : ad_ff[k];
         sh_c = '0;
         for (int b = 0; b < MAG_W; b++) begin
            if (m_c[b]) sh_c = SHIFT_W'(NORM_TOP - b);
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            ac1_ff[k] <= ac_ff[k]; ad1_ff[k] <= ad_ff[k];
            sh1_ff[k] <= sh_c; neg1_ff[k] <= neg0_ff[k];
         end
      end

      // Apply the shift and load the CORDIC.
      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[k][0] <= $signed(CORDIC_W'(ad1_ff[k]) << sh1_ff[k]);
            cy_ff[k][0] <= $signed(CORDIC_W'(ac1_ff[k]) << sh1_ff[k]);
            cz_ff[k][0] <= '0;
            cn_ff[k][0] <= neg1_ff[k];
         end
      end

      // Vectoring iterations, one per stage.
      for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
         logic signed [CORDIC_W-1:0] xs, ys;
         assign xs = cx_ff[k][i] >>> i;
         assign ys = cy_ff[k][i] >>> i;
         always_ff @(posedge clock) begin
            if (en) begin
               cn_ff[k][i+1] <= cn_ff[k][i];
               if (cy_ff[k][i] > 0) begin
                  cx_ff[k][i+1] <= cx_ff[k][i] + ys;
                  cy_ff[k][i+1] <= cy_ff[k][i] - xs;
                  cz_ff[k][i+1] <= cz_ff[k][i] + $signed(atan_entry(i));
               end else if (cy_ff[k][i] < 0) begin
                  cx_ff[k][i+1] <= cx_ff[k][i] - ys;
                  cy_ff[k][i+1] <= cy_ff[k][i] + xs;
                  cz_ff[k][i+1] <= cz_ff[k][i] - $signed(atan_entry(i));
               end else begin
                  cx_ff[k][i+1] <= cx_ff[k][i];
                  cy_ff[k][i+1] <= cy_ff[k][i];
                  cz_ff[k][i+1] <= cz_ff[k][i];
               end
            end
         end
      end

      // Clamp to a quarter turn and fold for an obtuse pair.
      always_ff @(posedge clock) begin
         logic signed [Z_W-1:0] zq;
         if (en) begin
            zq = cz_ff[k][CORDIC_STEPS];
            if (zq < 0) zq = '0;
            if (zq > (Z_W'(1) <<< 30)) zq = Z_W'(1) <<< 30;
            zf_ff[k] <= cn_ff[k][CORDIC_STEPS] ? 32'h8000_0000 - 32'(zq) : 32'(zq);
         end
      end

      // Scale to centidegrees.
      always_ff @(posedge clock) begin
         if (en) pr_ff[k] <= 48'(zf_ff[k]) * 48'd36000;
      end
      always_comb begin
         logic [47:0] t;
         t = pr_ff[k] + 48'h0000_8000_0000;
         cd_c[k] = t[47:32];
      end
   end

   // Reflex correction and the degenerate case into the output register.
   always_ff @(posedge clock) begin
      if (en) begin
         deg_ff <= dg_ff[BACK_STAGES-1];
         if (dg_ff[BACK_STAGES-1]) begin
            a0_ff <= '0; a1_ff <= '0; a2_ff <= '0;
         end else begin
            a0_ff <= cd_c[0];
            a1_ff <= rr_ff[BACK_STAGES-1] ? FULL_TURN_CDEG - cd_c[1] : cd_c[1];
            a2_ff <= rl_ff[BACK_STAGES-1] ? FULL_TURN_CDEG - cd_c[2] : cd_c[2];
         end
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.angle_top_pair     = a0_ff;
   assign rsp.angle_right_bottom = a1_ff;
   assign rsp.angle_left_bottom  = a2_ff;
   assign rsp.degenerate         = deg_ff;
endmodule
`default_nettype wire

FILE: rtl/three_beacon_bearing_angles_unit.sv
// Path: the edge that accepts a request word loads the first of 2 front
// stages; the word then passes 1 queue stage, 35 back stages and the
// output register, which offers its response word. Throughput: one word
// per cycle while rsp_chan is ready, set by the fully pipelined CORDIC lanes.
// Reset: synchronous, active high; clears all valid state and loads
// half_width = 1050 and field_length = 3000.
// ---------------------------------------------------------------------------
// three_beacon_bearing_angles_unit: top level
// Holds the field registers and connects front end, queue and back end.
// ---------------------------------------------------------------------------
`default_nettype none
module three_beacon_bearing_angles_unit import tbba_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   tbba_req_if.sink   req_chan,
   tbba_rsp_if.source rsp_chan,
   tbba_csr_if.sink   csr_chan
);
   logic [HW_BITS-1:0]    half_width_ff;
   logic [COORD_BITS-1:0] field_length_ff;
   logic                  f_valid, f_ready, q_valid, q_ready;
   word_type              f_word, q_word;

   // Field registers.
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff   <= HALF_WIDTH_RESET;
         field_length_ff <= FIELD_LENGTH_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_HALF_WIDTH:   half_width_ff   <= csr_chan.data[HW_BITS-1:0];
            CSR_FIELD_LENGTH: field_length_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   tbba_front u_front (
      .clock, .reset,
      .in_valid (req_chan.valid), .in_ready (req_chan.ready),
      .pos_x (req_chan.pos_x), .pos_y (req_chan.pos_y),
      .half_width (half_width_ff), .field_length (field_length_ff),
      .out_valid (f_valid), .out_ready (f_ready), .out_word (f_word)
   );

   tbba_queue u_queue (
      .clock, .reset,
      .in_valid (f_valid), .in_ready (f_ready), .in_word (f_word),
      .out_valid (q_valid), .out_ready (q_ready), .out_word (q_word)
   );

   tbba_back u_back (
      .clock, .reset,
      .in_valid (q_valid), .in_ready (q_ready), .in_word (q_word),
      .rsp (rsp_chan)
   );
endmodule
`default_nettype wire

FILE: rtl/tbba_checker.sv
// ---------------------------------------------------------------------------
// tbba_props: port-level checks
// Watches the response channel of the bearing angles unit.
// ---------------------------------------------------------------------------
`default_nettype none
module tbba_props import tbba_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [ANGLE_W-1:0] rsp_top,
   input wire logic [ANGLE_W-1:0] rsp_right,
   input wire logic [ANGLE_W-1:0] rsp_left,
   input wire logic               rsp_degen
);
   // A stalled response word stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // A beacon hit reports all angles as zero.
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degen |-> rsp_top == '0 && rsp_right == '0 && rsp_left == '0)
      else $error("degenerate word with nonzero angles");

   // The top pair angle never exceeds a half turn.
   a_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_top <= 16'd18000)
      else $error("top pair angle out of range");

   // Bottom angles stay within a full turn.
   a_bottom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_right <= 16'd36000 && rsp_left <= 16'd36000)
      else $error("bottom angle out of range");
endmodule

bind three_beacon_bearing_angles_unit tbba_props u_tbba_checker (
   .clock (clock), .reset (reset),
   .rsp_valid (rsp_chan.valid), .rsp_ready (rsp_chan.ready),
   .rsp_top (rsp_chan.angle_top_pair), .rsp_right (rsp_chan.angle_right_bottom),
   .rsp_left (rsp_chan.angle_left_bottom), .rsp_degen (rsp_chan.degenerate)
);
`default_nettype wire

FILE: test/tbba_checker.sv
// ---------------------------------------------------------------------------
// tbba_checker: response predictor and scoreboard
// Watches the request, response and register channels of the bearing
// angles unit, predicts each response word and compares it in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module tbba_checker import tbba_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   tbba_req_if       req_mon,
   tbba_rsp_if       rsp_mon,
   tbba_csr_if       csr_mon,
   output int        fail_count,
   output int        pending_count,
   output int        seen_count,
   output int        degen_count
);

   typedef struct packed {
      logic [ANGLE_W-1:0] top_pair;
      logic [ANGLE_W-1:0] right_bottom;
      logic [ANGLE_W-1:0] left_bottom;
      logic               degenerate;
   } bearing_type;

   localparam longint ARCTAN_TURN [CORDIC_STEPS] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
   };

   logic [HW_BITS-1:0]    half_width;
   logic [COORD_BITS-1:0] field_length;
   bearing_type           bearing_queue [$];

   // Unsigned angle between two beacon vectors in centidegrees (0..18000).
   function automatic longint pair_cdeg(longint ux, longint uy, longint vx, longint vy);
      longint crs, dotp, ac, ad, m, x, y, z, xs, ys;
      crs = ux * vy - uy * vx;
      dotp = ux * vx + uy * vy;
      ac = (crs < 0) ? -crs : crs;
      ad = (dotp < 0) ? -dotp : dotp;
      m = (ac > ad) ? ac : ad;
      z = 0;
      // Normalize so the larger member has its top bit at NORM_TOP.
      if (m != 0) begin
         while (m < (64'sd1 <<< NORM_TOP)) begin
            m = m <<< 1;
            ac = ac <<< 1;
            ad = ad <<< 1;
         end
      end
      x = ad;
      y = ac;
      // Vectoring rotation; arithmetic shifts round toward minus infinity.
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ARCTAN_TURN[i];
         end else if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ARCTAN_TURN[i];
         end
      end
      if (z < 0) z = 0;
      if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
      if (dotp < 0) z = (64'sd1 <<< 31) - z;
      return (z * 36000 + (64'sd1 <<< 31)) >>> 32;
   endfunction

   // Expected response word for one robot position.
   function automatic bearing_type predict_bearings(logic [COORD_BITS-1:0] px,
                                                    logic [COORD_BITS-1:0] py);
      longint h, l, x, y, alpha, beta, gamma;
      bearing_type b;
      h = longint'(half_width);
      l = longint'(field_length);
      x = longint'(px);
      y = longint'(py);
      b = '0;
      if (x > 2 * h) x = 2 * h;
      if (y > l) y = l;
      // Robot on one of the beacons.
      if ((x == h && y == 0) || (x == 0 && y == l) || (x == 2 * h && y == l)) begin
         b.degenerate = 1'b1;
         return b;
      end
      alpha = pair_cdeg(-x, l - y, 2 * h - x, l - y);
      beta  = pair_cdeg(2 * h - x, l - y, h - x, -y);
      gamma = pair_cdeg(-x, l - y, h - x, -y);
      // Reflex correction outside the lines to the bottom beacon.
      if (x * l < h * (l - y)) gamma = 36000 - gamma;
      if ((2 * h - x) * l < h * (l - y)) beta = 36000 - beta;
      b.top_pair     = alpha[ANGLE_W-1:0];
      b.right_bottom = beta[ANGLE_W-1:0];
      b.left_bottom  = gamma[ANGLE_W-1:0];
      return b;
   endfunction

   assign pending_count = bearing_queue.size();

   // Register shadow, prediction on accepted requests, compare on responses.
   always @(posedge clock) begin
      bearing_type got, want;
      if (reset) begin
         half_width   <= HALF_WIDTH_RESET;
         field_length <= FIELD_LENGTH_RESET;
         bearing_queue.delete();
         fail_count   <= 0;
         seen_count   <= 0;
         degen_count  <= 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_HALF_WIDTH)
               half_width <= csr_mon.data[HW_BITS-1:0];
            else if (csr_mon.index == CSR_FIELD_LENGTH)
               field_length <= csr_mon.data;
         end
         if (req_mon.valid && req_mon.ready)
            bearing_queue.push_back(predict_bearings(req_mon.pos_x, req_mon.pos_y));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.angle_top_pair, rsp_mon.angle_right_bottom,
                    rsp_mon.angle_left_bottom, rsp_mon.degenerate};
            seen_count <= seen_count + 1;
            if (bearing_queue.size() == 0) begin
               $display("%0t: unexpected response word %h", $realtime, got);
               fail_count <= fail_count + 1;
            end else begin
               want = bearing_queue.pop_front();
               if (want.degenerate) degen_count <= degen_count + 1;
               if (got != want) begin
                  $display("%0t: mismatch expected top %0d rb %0d lb %0d dg %0b",
                           $realtime, want.top_pair, want.right_bottom,
                           want.left_bottom, want.degenerate);
                  $display("%0t:          actual   top %0d rb %0d lb %0d dg %0b",
                           $realtime, got.top_pair, got.right_bottom,
                           got.left_bottom, got.degenerate);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for the three beacon bearing angles unit
// Drives robot positions and field register settings with random gaps and
// response back-pressure; the checker predicts and compares every word.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;
   import tbba_pkg::*;

   localparam int CYCLE_LIMIT   = 2000000;
   localparam int DRAIN_CYCLES  = 60;
   localparam int PHASE_ITEMS   = 205;
   localparam int LONG_HOLD     = 400;
   // Register indexes that select no register.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   fail_count, pending_count, seen_count, degen_count;
   int   hold_request = 0;
   int   sent_count = 0;
   logic [HW_BITS-1:0]    cur_half;
   logic [COORD_BITS-1:0] cur_length;

   tbba_req_if req_chan ();
   tbba_rsp_if rsp_chan ();
   tbba_csr_if csr_chan ();

   three_beacon_bearing_angles_unit u_top (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   tbba_checker u_checker (
      .clock(clock), .reset(reset),
      .req_mon(req_chan), .rsp_mon(rsp_chan), .csr_mon(csr_chan),
      .fail_count(fail_count), .pending_count(pending_count),
      .seen_count(seen_count), .degen_count(degen_count)
   );

   always #2 clock = ~clock;

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Gap length: mostly short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response side: random stalls, plus one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            rsp_chan.ready <= (stall_left == 0);
         end
      end
   end

   // Send one position word and wait for it to be taken.
   task automatic send_pos(input logic [COORD_BITS-1:0] px,
                           input logic [COORD_BITS-1:0] py, input bit gaps);
      int gap;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.pos_x <= px;
      req_chan.pos_y <= py;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      sent_count++;
      @(negedge clock);
   endtask

   // Wait until every expected word is back and the pipeline is empty.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // One register write word.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [COORD_BITS-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      if (idx == CSR_HALF_WIDTH) cur_half = value[HW_BITS-1:0];
      if (idx == CSR_FIELD_LENGTH) cur_length = value;
   endtask

   task automatic set_field(input int hw, input int len);
      drain();
      write_reg(CSR_HALF_WIDTH, COORD_BITS'(hw));
      write_reg(CSR_FIELD_LENGTH, COORD_BITS'(len));
   endtask

   // Random positions: mostly on the field, some beyond it, some on beacons.
   task automatic random_phase(input int count);
      int r, xmax;
      logic [COORD_BITS-1:0] px, py;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         xmax = 2 * int'(cur_half);
         if (xmax > 4094) xmax = 4094;
         if (r < 70) begin
            px = COORD_BITS'($urandom_range(0, xmax));
            py = COORD_BITS'($urandom_range(0, int'(cur_length)));
         end else if (r < 90) begin
            px = COORD_BITS'($urandom_range(0, 4094));
            py = COORD_BITS'($urandom_range(0, 4095));
         end else begin
            case ($urandom_range(0, 2))
               0: begin px = COORD_BITS'(cur_half); py = '0; end
               1: begin px = '0; py = cur_length; end
               default: begin px = COORD_BITS'(xmax); py = cur_length; end
            endcase
         end
         send_pos(px, py, 1'b1);
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_HALF_WIDTH;
      csr_chan.data  = '0;
      cur_half   = HALF_WIDTH_RESET;
      cur_length = FIELD_LENGTH_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words at the reset field size.
      send_pos(12'd0, 12'd0, 1'b0);
      send_pos(12'd4094, 12'd4095, 1'b0);
      send_pos(12'd1050, 12'd0, 1'b0);
      send_pos(12'd0, 12'd3000, 1'b0);
      send_pos(12'd2100, 12'd3000, 1'b0);
      send_pos(12'd4094, 12'd3000, 1'b0);
      send_pos(12'd1050, 12'd4095, 1'b0);
      send_pos(12'd1050, 12'd1500, 1'b0);
      send_pos(12'd10, 12'd2900, 1'b0);
      send_pos(12'd2090, 12'd2900, 1'b0);
      send_pos(12'd500, 12'd10, 1'b0);
      send_pos(12'd1600, 12'd10, 1'b0);
      send_pos(12'd1049, 12'd0, 1'b0);
      send_pos(12'd1051, 12'd1, 1'b0);
      send_pos(12'd0, 12'd2999, 1'b0);
      send_pos(12'd2100, 12'd2999, 1'b0);
      send_pos(12'd2048, 12'd2048, 1'b0);

      // Writes to unused indexes must leave the field alone.
      drain();
      write_reg(CSR_SPARE_LOW, 12'hFFF);
      write_reg(CSR_SPARE_HIGH, 12'h001);
      send_pos(12'd1050, 12'd0, 1'b0);
      send_pos(12'd700, 12'd700, 1'b0);

      // Reset field with one long response hold-off to fill the pipeline.
      hold_request = LONG_HOLD;
      random_phase(PHASE_ITEMS);

      // Largest field; the top bit of half_width data is dropped.
      set_field(12'hFFF, 4095);
      send_pos(12'd4094, 12'd4095, 1'b0);
      send_pos(12'd2047, 12'd0, 1'b0);
      random_phase(PHASE_ITEMS);

      // Smallest legal field.
      set_field(1, 1);
      random_phase(PHASE_ITEMS / 2);

      // Zero registers: beacons collapse.
      set_field(0, 0);
      random_phase(40);
      set_field(2047, 1);
      random_phase(PHASE_ITEMS / 2);
      set_field(1, 4095);
      random_phase(PHASE_ITEMS / 2);

      // Random field sizes.
      for (int p = 0; p < 3; p++) begin
         set_field($urandom_range(1, 2047), $urandom_range(1, 4095));
         random_phase(PHASE_ITEMS);
      end

      drain();
      $display("Sent %0d position words over nine field settings, %0d responses checked.",
               sent_count, seen_count);
      $display("Beacon hits: %0d; one long response hold-off applied.", degen_count);
      if (fail_count == 0 && pending_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
